// File: design/three_level_page_table_walker_defines.svh
// assertion macros used by the page table walker checker
`ifndef THREE_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define THREE_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define TLPTW_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define TLPTW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/tlptw_pkg.sv
// shared types and constants of the three-level page table walker
package tlptw_pkg;

   // field widths fixed by the channel layout
   localparam int unsigned ENTRY_BITS     = 64;
   localparam int unsigned ADDR_BITS      = 64;
   localparam int unsigned INDEX_BITS     = 10;
   localparam int unsigned WORD_IDX_BITS  = 16;
   localparam int unsigned NEED_BITS      = 3;
   localparam int unsigned REQ_TDATA_BITS = 152;
   localparam int unsigned RSP_TDATA_BITS = 72;

   // request command codes carried on tuser
   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   // page table entry bit positions
   localparam int unsigned E_VALID  = 0;
   localparam int unsigned E_FOR    = 1;
   localparam int unsigned E_FOE    = 3;
   localparam int unsigned E_KREAD  = 8;
   localparam int unsigned E_URED   = 9;
   localparam int unsigned E_KWRITE = 12;
   localparam int unsigned E_UWRITE = 13;
   localparam int unsigned E_FRAME  = 32;

   // translation status codes
   typedef enum logic [2:0] {
      ST_OK  = 3'd0,
      ST_ACV = 3'd1,
      ST_TNV = 3'd2,
      ST_FOE = 3'd3,
      ST_FOW = 3'd4,
      ST_FOR = 3'd5
   } status_type;

   // which table level the shared address unit indexes
   typedef enum logic [1:0] {
      LVL_1 = 2'd0,
      LVL_2 = 2'd1,
      LVL_3 = 2'd2
   } level_type;

   // which check the shared unit applies this cycle
   typedef enum logic [1:0] {
      STEP_PRE   = 2'd0,
      STEP_UPPER = 2'd1,
      STEP_FINAL = 2'd2
   } step_type;

   // walk sequencer states
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_START = 5'b00010,
      S_L1    = 5'b00100,
      S_L2    = 5'b01000,
      S_L3    = 5'b10000
   } state_type;

   // outcome of one check step
   typedef struct packed {
      logic                  done;
      status_type            status;
      logic [ADDR_BITS-1:0]  phys;
      logic [NEED_BITS-1:0]  rights;
   } result_type;

endpackage

// File: design/tlptw_mem.sv
// page table memory, one write port and one registered read port
module tlptw_mem #(
   parameter int unsigned MEM_ADDR_BITS = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [MEM_ADDR_BITS-1:0]            wr_addr,
   input  logic [tlptw_pkg::ENTRY_BITS-1:0]    wr_data,
   input  logic                                rd_en,
   input  logic [MEM_ADDR_BITS-1:0]            rd_addr,
   output logic [tlptw_pkg::ENTRY_BITS-1:0]    rd_data
);
   import tlptw_pkg::*;

   localparam int unsigned DEPTH = 1 << MEM_ADDR_BITS;

   logic [ENTRY_BITS-1:0] table_ff [0:DEPTH-1];
   logic [ENTRY_BITS-1:0] rd_data_ff;

   // word write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/tlptw_walk_unit.sv
// shared walk unit: table address adder and entry check for every step
module tlptw_walk_unit #(
   parameter int unsigned PAGE_SHIFT    = 13,
   parameter int unsigned VIRT_BITS     = 43,
   parameter int unsigned MEM_ADDR_BITS = 16
) (
   input  tlptw_pkg::level_type                 level,
   input  tlptw_pkg::step_type                  step,
   input  logic [tlptw_pkg::ADDR_BITS-1:0]      va,
   input  logic                                 privilege,
   input  logic [tlptw_pkg::NEED_BITS-1:0]      access_need,
   input  logic [tlptw_pkg::ADDR_BITS-1:0]      table_base,
   input  logic [tlptw_pkg::ENTRY_BITS-1:0]     entry,
   output logic [MEM_ADDR_BITS-1:0]             rd_addr,
   output tlptw_pkg::result_type                check
);
   import tlptw_pkg::*;

   logic [ADDR_BITS-1:0]  frame_base;
   logic [ADDR_BITS-1:0]  base;
   logic [INDEX_BITS-1:0] idx;
   logic [ADDR_BITS-1:0]  byte_addr;
   logic                  sign_ok;
   logic                  superpage;
   logic                  may_read;
   logic                  may_write;
   logic [NEED_BITS-1:0]  prot;
   logic [NEED_BITS-1:0]  prot_left;
   result_type            pre_res;
   result_type            upper_res;
   result_type            final_res;

   // next table or page base from the entry frame number
   assign frame_base = ADDR_BITS'(entry[ENTRY_BITS-1:E_FRAME]) << PAGE_SHIFT;
   assign base       = (level == LVL_1) ? table_base : frame_base;

   // ten index bits per level above the page offset
   always_comb begin
      unique case (level)
         LVL_1:   idx = va[PAGE_SHIFT+2*INDEX_BITS +: INDEX_BITS];
         LVL_2:   idx = va[PAGE_SHIFT+INDEX_BITS +: INDEX_BITS];
         default: idx = va[PAGE_SHIFT +: INDEX_BITS];
      endcase
   end

   // entry byte address, word select wraps to the memory size
   assign byte_addr = base + {{(ADDR_BITS-INDEX_BITS-3){1'b0}}, idx, 3'b000};
   assign rd_addr   = byte_addr[MEM_ADDR_BITS+2:3];

   // sign extension and kernel superpage decode
   assign sign_ok   = (va[ADDR_BITS-1:VIRT_BITS] == {(ADDR_BITS-VIRT_BITS){va[ADDR_BITS-1]}});
   assign superpage = va[ADDR_BITS-1] && (va[42:41] == 2'b10);

   always_comb begin
      pre_res = '{done: 1'b0, status: ST_OK, phys: '0, rights: '0};
      if (!sign_ok) begin
         pre_res.done   = 1'b1;
         pre_res.status = ST_ACV;
      end else if (superpage) begin
         pre_res.done = 1'b1;
         if (privilege) begin
            pre_res.status = ST_ACV;
         end else begin
            pre_res.phys   = {20'd0, va[40], 3'b000, va[39:0]};
            pre_res.rights = 3'b111;
         end
      end
   end

   // first and second level entries need valid and kernel read
   always_comb begin
      upper_res = '{done: 1'b0, status: ST_OK, phys: '0, rights: '0};
      if (!entry[E_VALID]) begin
         upper_res.done   = 1'b1;
         upper_res.status = ST_TNV;
      end else if (!entry[E_KREAD]) begin
         upper_res.done   = 1'b1;
         upper_res.status = ST_ACV;
      end
   end

   // third level permission check
   assign may_read  = privilege ? entry[E_URED] : entry[E_KREAD];
   assign may_write = privilege ? entry[E_UWRITE] : entry[E_KWRITE];
   assign prot      = {may_read, may_write, may_read};
   assign prot_left = prot & ~entry[E_FOE:E_FOR];

   always_comb begin
      final_res = '{done: 1'b1, status: ST_OK, phys: frame_base, rights: '0};
      priority if (!entry[E_VALID]) begin
         final_res.status = ST_TNV;
      end else if ((access_need != '0) && ((prot & access_need) == '0)) begin
         final_res.status = ST_ACV;
         final_res.rights = prot;
      end else begin
         final_res.rights = prot_left;
         if ((prot_left & access_need) == '0) begin
            priority if (access_need[2]) begin
               final_res.status = ST_FOE;
            end else if (access_need[1]) begin
               final_res.status = ST_FOW;
            end else if (access_need[0]) begin
               final_res.status = ST_FOR;
            end else begin
               final_res.status = ST_OK;
            end
         end
      end
   end

   // pick the check of the current step
   always_comb begin
      unique case (step)
         STEP_PRE:   check = pre_res;
         STEP_UPPER: check = upper_res;
         default:    check = final_res;
      endcase
   end

endmodule

// File: design/tlptw_seq.sv
// walk sequencer: request registers, step control and result register
module tlptw_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [tlptw_pkg::ADDR_BITS-1:0]      req_va,
   input  logic                                 req_privilege,
   input  logic [tlptw_pkg::NEED_BITS-1:0]      req_need,
   output logic                                 idle,
   output tlptw_pkg::level_type                 level,
   output tlptw_pkg::step_type                  step,
   output logic [tlptw_pkg::ADDR_BITS-1:0]      va,
   output logic                                 privilege,
   output logic [tlptw_pkg::NEED_BITS-1:0]      access_need,
   output logic                                 rd_en,
   input  tlptw_pkg::result_type                check,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tlptw_pkg::result_type                rsp_result
);
   import tlptw_pkg::*;

   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] va_ff;
   logic                 priv_ff;
   logic [NEED_BITS-1:0] need_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           result_ff;
   logic                 out_free;
   logic                 load;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // step control
   always_comb begin
      state_in = state_ff;
      level    = LVL_1;
      step     = STEP_PRE;
      rd_en    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_START;
            end
         end
         S_START: begin
            level = LVL_1;
            step  = STEP_PRE;
            if (check.done) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_L1;
            end
         end
         S_L1: begin
            level = LVL_2;
            step  = STEP_UPPER;
            if (check.done) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_L2;
            end
         end
         S_L2: begin
            level = LVL_3;
            step  = STEP_UPPER;
            if (check.done) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_L3;
            end
         end
         S_L3: begin
            level = LVL_3;
            step  = STEP_FINAL;
            if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared when taken
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (start && (state_ff == S_IDLE)) begin
         va_ff   <= req_va;
         priv_ff <= req_privilege;
         need_ff <= req_need;
      end
      if (load) begin
         result_ff <= check;
      end
   end

   assign idle        = (state_ff == S_IDLE);
   assign va          = va_ff;
   assign privilege   = priv_ff;
   assign access_need = need_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_result  = result_ff;

endmodule

// File: design/three_level_page_table_walker.sv
// top level of the three-level page table walker
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tdata: request fields, tuser: command
//   rsp      out        rsp_tvalid/tready    tdata: status, address, rights
//   csr      in         csr_valid/ready      csr_data: table base
//
// a table write leaves the block ready again at once.
// a translation loads its result in the start state when the sign or
// superpage decode settles it, else in the level 1, 2 or 3 state for a
// walk ending at that level: at most three dependent reads through the one
// read port of the table memory, each checked by the shared walk unit.
// the block takes no request until the result is in the output register,
// which waits while rsp_tready is low; reset clears the table base and the
// sequencer but not the table memory.
module three_level_page_table_walker #(
   parameter int unsigned PAGE_SHIFT    = 13,
   parameter int unsigned VIRT_BITS     = 43,
   parameter int unsigned MEM_ADDR_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // virtual_address, privilege, access_need, word_index, word_data, zero pad
   input  logic [tlptw_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   // command
   input  logic                                    req_tuser,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // status, physical_address, rights, zero pad
   output logic [tlptw_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic [tlptw_pkg::ADDR_BITS-1:0]         csr_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready
);
   import tlptw_pkg::*;

   logic [ADDR_BITS-1:0]     table_base_ff;
   logic [ADDR_BITS-1:0]     in_va;
   logic                     in_priv;
   logic [NEED_BITS-1:0]     in_need;
   logic [WORD_IDX_BITS-1:0] in_word_index;
   logic [ENTRY_BITS-1:0]    in_word_data;
   logic                     req_accept;
   logic                     wr_en;
   logic                     start;
   logic                     idle;
   level_type                level;
   step_type                 step;
   logic [ADDR_BITS-1:0]     va;
   logic                     privilege;
   logic [NEED_BITS-1:0]     access_need;
   logic                     rd_en;
   logic [MEM_ADDR_BITS-1:0] rd_addr;
   logic [ENTRY_BITS-1:0]    entry;
   result_type               check;
   result_type               rsp_result;

   // request field unpack
   assign in_va         = req_tdata[63:0];
   assign in_priv       = req_tdata[64];
   assign in_need       = req_tdata[67:65];
   assign in_word_index = req_tdata[83:68];
   assign in_word_data  = req_tdata[147:84];

   assign req_tready = idle;
   assign req_accept = req_tvalid && req_tready;
   assign wr_en      = req_accept && (req_tuser == CMD_WRITE);
   assign start      = req_accept && (req_tuser == CMD_TRANSLATE);

   // table base register, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         table_base_ff <= csr_data;
      end
   end

   tlptw_mem #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (MEM_ADDR_BITS'(in_word_index)),
      .wr_data (in_word_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (entry)
   );

   tlptw_walk_unit #(
      .PAGE_SHIFT    (PAGE_SHIFT),
      .VIRT_BITS     (VIRT_BITS),
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_walk_unit (
      .level       (level),
      .step        (step),
      .va          (va),
      .privilege   (privilege),
      .access_need (access_need),
      .table_base  (table_base_ff),
      .entry       (entry),
      .rd_addr     (rd_addr),
      .check       (check)
   );

   tlptw_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_va        (in_va),
      .req_privilege (in_priv),
      .req_need      (in_need),
      .idle          (idle),
      .level         (level),
      .step          (step),
      .va            (va),
      .privilege     (privilege),
      .access_need   (access_need),
      .rd_en         (rd_en),
      .check         (check),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_result    (rsp_result)
   );

   // result pack
   assign rsp_tdata = {2'b00, rsp_result.rights, rsp_result.phys, rsp_result.status};

endmodule

// File: design/tlptw_checker.sv
// port-level checker for the page table walker, bound to the top level
`include "three_level_page_table_walker_defines.svh"

module tlptw_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  req_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [tlptw_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata
);
   import tlptw_pkg::*;

   // a stalled result holds its payload
   `TLPTW_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // a translation keeps the request side busy
   `TLPTW_ASSERT_NEXT(a_walk_busy, req_tvalid && req_tready && (req_tuser == CMD_TRANSLATE), !req_tready, "request taken during a walk")

   // a table write leaves the block ready
   `TLPTW_ASSERT_NEXT(a_write_ready, req_tvalid && req_tready && (req_tuser == CMD_WRITE), req_tready, "not ready after table write")

   // a new result only appears as its walk ends
   `TLPTW_ASSERT_SAME(a_rsp_end, $rose(rsp_tvalid), req_tready && (rsp_tdata[2:0] <= ST_FOR), "result outside a walk end")

endmodule

bind three_level_page_table_walker tlptw_checker u_checker (.*);

// File: dv/tb_three_level_page_table_walker.sv
`timescale 1ns / 1ps
// self-checking testbench: directed and random page table walks against a shadow table
module tb_three_level_page_table_walker;
   import tlptw_pkg::*;

   localparam int unsigned PG_SHIFT    = 13;
   localparam int unsigned VA_BITS     = 43;
   localparam int unsigned MEM_BITS    = 16;
   localparam int unsigned MEM_WORDS   = 1 << MEM_BITS;
   localparam int unsigned IDLE_LIMIT  = 2000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned PHASE_ITEMS = 300;

   localparam logic       PRIV_KERNEL = 1'b0;
   localparam logic       PRIV_USER   = 1'b1;
   localparam logic [2:0] NEED_NONE   = 3'b000;
   localparam logic [2:0] RIGHT_READ  = 3'b001;
   localparam logic [2:0] RIGHT_WRITE = 3'b010;
   localparam logic [2:0] RIGHT_EXEC  = 3'b100;
   localparam logic [2:0] RIGHT_ALL   = RIGHT_READ | RIGHT_WRITE | RIGHT_EXEC;

   // entry bit patterns
   localparam logic [63:0] PTE_VLD    = 64'd1 << E_VALID;
   localparam logic [63:0] PTE_KREAD  = 64'd1 << E_KREAD;
   localparam logic [63:0] PTE_UREAD  = 64'd1 << E_URED;
   localparam logic [63:0] PTE_KWRITE = 64'd1 << E_KWRITE;
   localparam logic [63:0] TABLE_OK   = PTE_VLD | PTE_KREAD;

   // directed walk setup: unaligned base whose first level wraps to the top word
   localparam logic [63:0] DIRECTED_BASE = 64'hFFFF_FFFF_FFFF_FFFD;
   localparam logic [63:0] SUPER_VA      = 64'hFFFF_FD12_3456_789A;
   localparam logic [63:0] L3_FRAME      = 64'h1234_5678_0000_0000;

   typedef struct packed {
      status_type  status;
      logic [63:0] phys;
      logic [2:0]  rights;
   } walk_result_type;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_COIN,
      FLOW_SPARSE,
      FLOW_PERIODIC
   } ready_pattern_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic                      req_tuser;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [ADDR_BITS-1:0]      csr_data;
   logic                      csr_valid;
   logic                      csr_ready;

   // shadow copy of the walker state
   logic [63:0]     shadow_base;
   logic [63:0]     shadow_table [MEM_WORDS];
   bit              shadow_written [MEM_WORDS];
   walk_result_type pending_walks [$];
   logic [63:0]     va_pool [$];

   int burst_left;
   int items_sent;
   int fail_count;
   int idle_cycles;
   int stall_left;
   int stall_phase;
   ready_pattern_type stall_mode;

   three_level_page_table_walker #(
      .PAGE_SHIFT    (PG_SHIFT),
      .VIRT_BITS     (VA_BITS),
      .MEM_ADDR_BITS (MEM_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #5 clock = ~clock;

   // table word read at one level: byte address / 8, wrapped to memory size
   function automatic logic [MEM_BITS-1:0] word_of(input logic [63:0] tbl,
         input logic [63:0] va, input int lvl);
      logic [63:0] addr;
      addr = tbl + (((va >> (PG_SHIFT + 10 * (3 - lvl))) & 64'h3ff) << 3);
      return addr[MEM_BITS+2:3];
   endfunction

   function automatic logic [63:0] frame_base(input logic [63:0] e);
      return {32'd0, e[63:32]} << PG_SHIFT;
   endfunction

   // expected translation; reports the first unwritten word the walk would read
   function automatic walk_result_type walk_page_tables(input logic [63:0] va,
         input logic priv, input logic [2:0] need,
         output int missing_word, output int missing_level);
      walk_result_type r;
      logic [63:0] tbl;
      logic [63:0] e;
      logic [MEM_BITS-1:0] w;
      logic [2:0] prot;
      int lvl;
      r.status = ST_OK;
      r.phys = '0;
      r.rights = '0;
      missing_word = -1;
      missing_level = 0;
      tbl = shadow_base;
      e = '0;
      prot = '0;
      if (va[63:VA_BITS] != {(64 - VA_BITS){va[63]}}) begin
         r.status = ST_ACV;
         return r;
      end
      // kernel superpage
      if (va[63] && va[42:41] == 2'b10) begin
         if (priv == PRIV_USER) begin
            r.status = ST_ACV;
         end else begin
            r.phys = {20'd0, va[40], 3'd0, va[39:0]};
            r.rights = RIGHT_ALL;
         end
         return r;
      end
      for (lvl = 1; lvl <= 3; lvl++) begin
         w = word_of(tbl, va, lvl);
         if (!shadow_written[w]) begin
            missing_word = int'(w);
            missing_level = lvl;
            return r;
         end
         e = shadow_table[w];
         if (lvl < 3) begin
            if (!e[E_VALID]) begin
               r.status = ST_TNV;
               return r;
            end
            if (!e[E_KREAD]) begin
               r.status = ST_ACV;
               return r;
            end
            tbl = frame_base(e);
         end
      end
      // last level: rights, then fault-on clearing
      r.phys = frame_base(e);
      if (!e[E_VALID]) begin
         r.status = ST_TNV;
         return r;
      end
      if (e[E_KREAD + priv]) prot = prot | RIGHT_READ | RIGHT_EXEC;
      if (e[E_KWRITE + priv]) prot = prot | RIGHT_WRITE;
      if ((prot & need) == 0 && need != NEED_NONE) begin
         r.status = ST_ACV;
         r.rights = prot;
         return r;
      end
      prot = prot & ~e[E_FOE:E_FOR];
      r.rights = prot;
      if ((prot & need) == 0) begin
         if (need & RIGHT_EXEC) r.status = ST_FOE;
         else if (need & RIGHT_WRITE) r.status = ST_FOW;
         else if (need & RIGHT_READ) r.status = ST_FOR;
      end
      return r;
   endfunction

   // new table entry, mostly usable so walks get deep
   function automatic logic [63:0] fresh_entry(input int lvl);
      logic [63:0] e;
      e = {$urandom, $urandom};
      if (lvl < 3) begin
         if ($urandom_range(0, 99) < 88) e = e | TABLE_OK;
      end else begin
         if ($urandom_range(0, 99) < 85) e[E_VALID] = 1'b1;
         if ($urandom_range(0, 1)) e[E_FOE:E_FOR] = '0;
      end
      return e;
   endfunction

   function automatic logic [63:0] random_va();
      logic [63:0] va;
      logic [40:0] super_low;
      logic [VA_BITS-1:0] canon_low;
      int pick;
      pick = $urandom_range(0, 99);
      super_low = 41'({$urandom, $urandom});
      canon_low = VA_BITS'({$urandom, $urandom});
      if (pick < 6) begin
         va = {$urandom, $urandom};
         if (va[63:VA_BITS] == {(64 - VA_BITS){va[63]}}) va[50] = ~va[50];
      end else if (pick < 14) begin
         va = {{(64 - VA_BITS){1'b1}}, 2'b10, super_low};
      end else if (pick < 60 && va_pool.size() != 0) begin
         // revisit known tables with a new offset and maybe a new last-level index
         va = va_pool[$urandom_range(0, va_pool.size() - 1)];
         va[PG_SHIFT-1:0] = PG_SHIFT'($urandom);
         if ($urandom_range(0, 1)) va[PG_SHIFT+9:PG_SHIFT] = 10'($urandom);
      end else begin
         va = {{(64 - VA_BITS){canon_low[VA_BITS-1]}}, canon_low};
         va_pool.push_back(va);
         if (va_pool.size() > 32) void'(va_pool.pop_front());
      end
      return va;
   endfunction

   // one request transaction, sent in bursts with random gaps
   task automatic send_item(input logic cmd, input logic [63:0] va, input logic priv,
         input logic [2:0] need, input logic [15:0] widx, input logic [63:0] wdata,
         input walk_result_type expected);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 16);
      end
      @(negedge clock);
      req_tuser <= cmd;
      req_tdata <= {4'd0, wdata, widx, need, priv, va};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_TRANSLATE) pending_walks.push_back(expected);
      burst_left--;
      items_sent++;
   endtask

   task automatic write_word(input logic [15:0] widx, input logic [63:0] wdata);
      walk_result_type no_result;
      no_result = '0;
      shadow_table[widx] = wdata;
      shadow_written[widx] = 1'b1;
      send_item(CMD_WRITE, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                3'($urandom_range(0, 7)), widx, wdata, no_result);
   endtask

   // translate, first filling any table word the walk would read unwritten
   task automatic request_walk(input logic [63:0] va, input logic priv,
         input logic [2:0] need);
      walk_result_type want;
      int gap_word;
      int gap_level;
      want = walk_page_tables(va, priv, need, gap_word, gap_level);
      while (gap_word >= 0) begin
         write_word(gap_word[15:0], fresh_entry(gap_level));
         want = walk_page_tables(va, priv, need, gap_word, gap_level);
      end
      send_item(CMD_TRANSLATE, va, priv, need, 16'($urandom), {$urandom, $urandom}, want);
   endtask

   // write the entry that a walk of va reads at one level
   task automatic place_entry(input int lvl, input logic [63:0] va, input logic [63:0] data);
      logic [63:0] tbl;
      int k;
      tbl = shadow_base;
      for (k = 1; k < lvl; k++) tbl = frame_base(shadow_table[word_of(tbl, va, k)]);
      write_word(word_of(tbl, va, lvl), data);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_walks.size() != 0) @(posedge clock);
   endtask

   // base register write, only with the walker idle
   task automatic load_table_base(input logic [63:0] value);
      wait_for_results();
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      shadow_base = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_address_checks();
      load_table_base(DIRECTED_BASE);
      request_walk(64'h0000_0800_0000_0000, PRIV_KERNEL, RIGHT_READ);
      request_walk(64'h8000_0000_0000_0000, PRIV_USER, RIGHT_READ);
      request_walk(SUPER_VA, PRIV_KERNEL, RIGHT_ALL);
      request_walk(SUPER_VA, PRIV_USER, RIGHT_READ);
   endtask

   // each upper-level failure, then an invalid last level
   task automatic test_walk_levels();
      place_entry(1, 64'd0, 64'd0);
      request_walk(64'd0, PRIV_KERNEL, RIGHT_READ);
      place_entry(1, 64'd0, PTE_VLD);
      request_walk(64'd0, PRIV_KERNEL, RIGHT_READ);
      place_entry(1, 64'd0, TABLE_OK);
      place_entry(2, 64'd0, 64'd0);
      request_walk(64'd0, PRIV_KERNEL, RIGHT_READ);
      place_entry(2, 64'd0, PTE_VLD);
      request_walk(64'd0, PRIV_KERNEL, RIGHT_READ);
      place_entry(2, 64'd0, TABLE_OK | 64'h0000_0001_0000_0000);
      place_entry(3, 64'd0, L3_FRAME | PTE_KREAD | PTE_KWRITE);
      request_walk(64'd0, PRIV_KERNEL, RIGHT_READ);
   endtask

   // rights per privilege, no right granted, and each fault-on outcome
   task automatic test_rights_and_faults();
      place_entry(3, 64'd0, L3_FRAME | PTE_VLD | PTE_KREAD | PTE_KWRITE);
      request_walk(64'd0, PRIV_KERNEL, RIGHT_ALL);
      request_walk(64'd0, PRIV_USER, RIGHT_READ);
      place_entry(3, 64'd0, L3_FRAME | PTE_VLD | PTE_UREAD);
      request_walk(64'd0, PRIV_USER, RIGHT_WRITE);
      place_entry(3, 64'd0, '1);
      request_walk(64'd0, PRIV_KERNEL, RIGHT_ALL);
      request_walk(64'd0, PRIV_KERNEL, RIGHT_READ | RIGHT_WRITE);
      request_walk(64'd0, PRIV_KERNEL, RIGHT_READ);
      request_walk(64'd0, PRIV_KERNEL, NEED_NONE);
   endtask

   task automatic test_random_walks(input logic [63:0] base, input int count);
      int goal;
      load_table_base(base);
      goal = items_sent + count;
      while (items_sent < goal) begin
         if ($urandom_range(0, 99) < 8) write_word(16'($urandom), {$urandom, $urandom});
         else request_walk(random_va(), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
         if ($urandom_range(0, 199) == 0) wait_for_results();
      end
   endtask

   // result transaction check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      walk_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_walks.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("unexpected walk result at %0t: %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_walks.pop_front();
            if (rsp_tdata[2:0] !== want.status || rsp_tdata[66:3] !== want.phys ||
                rsp_tdata[69:67] !== want.rights) begin
               if (fail_count < MAX_REPORTS)
                  $display("walk mismatch at %0t: status %0d/%0d phys %h/%h rights %b/%b",
                           $time, want.status, rsp_tdata[2:0], want.phys, rsp_tdata[66:3],
                           want.rights, rsp_tdata[69:67]);
               fail_count++;
            end
         end
      end
   end

   // receiver back-pressure with a randomly changing ready pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = ready_pattern_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         FLOW_FREE: rsp_tready <= 1'b1;
         FLOW_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         FLOW_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_phase % 5) < 3;
      endcase
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tdata = '0;
      req_tuser = CMD_WRITE;
      req_tvalid = 1'b0;
      rsp_tready = 1'b0;
      csr_data = '0;
      csr_valid = 1'b0;
      shadow_base = '0;
      burst_left = 0;
      items_sent = 0;
      fail_count = 0;
      idle_cycles = 0;
      stall_left = 0;
      stall_phase = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_address_checks();
      test_walk_levels();
      test_rights_and_faults();
      test_random_walks(64'd0, PHASE_ITEMS);
      test_random_walks('1, PHASE_ITEMS);
      test_random_walks({$urandom, $urandom} | 64'd5, PHASE_ITEMS);
      test_random_walks({$urandom, $urandom}, PHASE_ITEMS);
      test_random_walks({$urandom, $urandom} & ~64'd7, PHASE_ITEMS);

      wait_for_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_walks.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
